// ----- sv/text_console_writer_top_macros.svh -----
// Assertion macros shared by the console writer checks.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define TXC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Implication form of the clocked check.
`define TXC_CHECK_IMP(lbl, ante, cons, msg) \
  `TXC_CHECK(lbl, (ante) |-> (cons), msg)

`endif

// ----- sv/txc_pkg.sv -----
// Shared constants, codes and controller/datapath interface types.
package txc_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Character codes
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Attribute used for blanks after reset
  localparam logic [7:0] ATTR_RST = 8'h07;

  // Request kinds
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Memory write source
  localparam logic [2:0] WR_NONE  = 3'd0;
  localparam logic [2:0] WR_CHAR  = 3'd1;
  localparam logic [2:0] WR_COPY  = 3'd2;
  localparam logic [2:0] WR_BLANK = 3'd3;
  localparam logic [2:0] WR_FILL  = 3'd4;
  localparam logic [2:0] WR_INIT  = 3'd5;

  // Memory read source
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_IDX  = 2'd1;
  localparam logic [1:0] RD_COPY = 2'd2;

  // Commands from the controller
  typedef struct packed {
    logic       take;
    logic [2:0] wr_mode;
    logic [1:0] rd_mode;
    logic       cur_put;
    logic       cur_home;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       out_load;
  } cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic [1:0] req;
    logic       plain;
    logic       scroll_need;
    logic       cnt_zero;
    logic       copy_end;
    logic       cnt_end;
    logic       out_free;
  } sts_t;

endpackage

// ----- sv/txc_datapath.sv -----
// Screen memory, cursor, request registers and result register.
module txc_datapath #(
  parameter int COLUMNS = txc_pkg::COLUMNS_DEF,
  parameter int ROWS    = txc_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  txc_pkg::cmd_t cmd,
  output txc_pkg::sts_t sts,
  input  logic [31:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  input  logic          cfg_valid,
  input  logic [7:0]    cfg_data,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata
);
  import txc_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
  localparam logic [AW-1:0] NCOPY_A  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [7:0]    COLS8    = 8'(COLUMNS);

  // Request registers
  logic [1:0]    req_r;
  logic [7:0]    char_r;
  logic [7:0]    attr_r;
  logic [10:0]   idx_r;
  // Cursor and sweep state
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          scr_r, scr_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    def_attr_r;
  // Memory and result
  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_r;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r;

  logic [RW-1:0] row_inc, row_put;
  logic [CW-1:0] col_put;
  logic          row_bot, wrap, plain;
  logic [7:0]    col8, plus1, tab;
  logic [AW-1:0] pos, wr_addr, rd_addr, idx_a;
  logic [AW+10:0] idx_x;
  logic [15:0]   wr_data;
  logic          idx_ok;
  logic [RW+4:0] row_x;
  logic [CW+6:0] col_x;
  logic [15:0]   rd_out;

  // Put decode: where the cursor goes and whether a row wrap happens
  always_comb begin
    row_bot = (row_r == ROW_LAST);
    row_inc = row_bot ? row_r : row_r + 1'b1;
    col8    = 8'(col_r);
    plus1   = col8 + 8'd1;
    tab     = (col8 + 8'd8) & 8'hF8;
    wrap    = 1'b0;
    plain   = 1'b0;
    col_put = col_r;
    case (char_r)
      CH_NEWLINE: begin
        wrap = 1'b1;
      end
      CH_RETURN: begin
        col_put = '0;
      end
      CH_TAB: begin
        if (tab >= COLS8) wrap = 1'b1;
        else              col_put = CW'(tab);
      end
      default: begin
        plain = 1'b1;
        if (plus1 >= COLS8) wrap = 1'b1;
        else                col_put = CW'(plus1);
      end
    endcase
    if (wrap) col_put = '0;
    row_put = wrap ? row_inc : row_r;
  end

  // Cursor and scroll flag next values
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    scr_nxt = scr_r;
    if (cmd.take) scr_nxt = 1'b0;
    if (cmd.cur_put) begin
      row_nxt = row_put;
      col_nxt = col_put;
      scr_nxt = wrap && row_bot;
    end
    if (cmd.cur_home) begin
      row_nxt = '0;
      col_nxt = '0;
    end
  end

  // Sweep counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr)      cnt_nxt = '0;
    else if (cmd.cnt_inc) cnt_nxt = cnt_r + 1'b1;
  end

  // Memory addressing
  always_comb begin
    pos    = AW'(row_r) * COLS_A + AW'(col_r);
    idx_x  = {{AW{1'b0}}, idx_r};
    idx_a  = idx_x[AW-1:0];
    idx_ok = (32'(idx_r) < 32'(CELLS));
    case (cmd.wr_mode)
      WR_CHAR: begin
        wr_addr = pos;
        wr_data = {attr_r, char_r};
      end
      WR_COPY: begin
        wr_addr = cnt_r - 1'b1;
        wr_data = rdata_r;
      end
      WR_BLANK: begin
        wr_addr = cnt_r;
        wr_data = {attr_r, CH_SPACE};
      end
      WR_FILL: begin
        wr_addr = cnt_r;
        wr_data = {def_attr_r, CH_SPACE};
      end
      WR_INIT: begin
        wr_addr = cnt_r;
        wr_data = {ATTR_RST, CH_SPACE};
      end
      default: begin
        wr_addr = cnt_r;
        wr_data = rdata_r;
      end
    endcase
    case (cmd.rd_mode)
      RD_IDX:  rd_addr = idx_a;
      RD_COPY: rd_addr = cnt_r + COLS_A;
      default: rd_addr = idx_a;
    endcase
  end

  // Screen memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_mode != WR_NONE) mem[wr_addr] <= wr_data;
    if (cmd.rd_mode != RD_NONE) rdata_r <= mem[rd_addr];
  end

  // Result fields
  always_comb begin
    row_x  = {5'b0, row_nxt};
    col_x  = {7'b0, col_nxt};
    rd_out = ((req_r == REQ_READ) && idx_ok) ? rdata_r : 16'h0000;
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      scr_r       <= 1'b0;
      cnt_r       <= '0;
      def_attr_r  <= ATTR_RST;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      scr_r       <= scr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) def_attr_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r  <= in_tuser;
      char_r <= in_tdata[7:0];
      attr_r <= in_tdata[15:8];
      idx_r  <= in_tdata[26:16];
    end
    if (cmd.out_load) begin
      out_data_r <= {3'b000, scr_nxt, col_x[6:0], row_x[4:0], rd_out};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status to the controller
  assign sts.req         = req_r;
  assign sts.plain       = plain;
  assign sts.scroll_need = wrap && row_bot;
  assign sts.cnt_zero    = (cnt_r == '0);
  assign sts.copy_end    = (cnt_r == NCOPY_A);
  assign sts.cnt_end     = (cnt_r == LAST_A);
  assign sts.out_free    = !out_valid_r || out_tready;

endmodule

// ----- sv/txc_ctrl.sv -----
// Request sequencer: decode, memory sweeps and result hand-off.
module txc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  txc_pkg::sts_t sts,
  output txc_pkg::cmd_t cmd
);
  import txc_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_COPY  = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.wr_mode = WR_INIT;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_end) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.req)
          REQ_PUT: begin
            if (sts.scroll_need) begin
              cmd.wr_mode = sts.plain ? WR_CHAR : WR_NONE;
              cmd.cur_put = 1'b1;
              cmd.cnt_clr = 1'b1;
              state_nxt   = S_COPY;
            end else if (sts.out_free) begin
              cmd.wr_mode  = sts.plain ? WR_CHAR : WR_NONE;
              cmd.cur_put  = 1'b1;
              cmd.out_load = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          REQ_CLEAR: begin
            cmd.cur_home = 1'b1;
            cmd.cnt_clr  = 1'b1;
            state_nxt    = S_FILL;
          end
          REQ_READ: begin
            cmd.rd_mode = RD_IDX;
            state_nxt   = S_DONE;
          end
          default: begin
            if (sts.out_free) begin
              cmd.out_load = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
        endcase
      end
      // Read one row down, write the cell read last cycle
      S_COPY: begin
        if (!sts.cnt_zero) cmd.wr_mode = WR_COPY;
        if (!sts.copy_end) begin
          cmd.rd_mode = RD_COPY;
          cmd.cnt_inc = 1'b1;
        end else begin
          state_nxt = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd.wr_mode = WR_BLANK;
        if (sts.cnt_end) state_nxt = S_DONE;
        else             cmd.cnt_inc = 1'b1;
      end
      S_FILL: begin
        cmd.wr_mode = WR_FILL;
        if (sts.cnt_end) state_nxt = S_DONE;
        else             cmd.cnt_inc = 1'b1;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/text_console_writer_top.sv -----
// Put: the request is taken in IDLE, then EXEC writes memory and loads the result; read:
// EXEC reads the cell, then DONE loads the result. Scroll and clear sweep the screen; a scroll
// sweep uses the read and the write port of the screen memory (copy, then last-row blank).
// One request in flight; a result stalled at the output adds its wait cycles.
// Reset: synchronous, active low; afterward a pass blanks every cell of
// the screen to 0x0720 while no request is taken (config writes still taken).
module text_console_writer_top #(
  parameter int COLUMNS = txc_pkg::COLUMNS_DEF,
  parameter int ROWS    = txc_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code[7:0], attr[15:8], cell_index[26:16]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_data[15:0], cursor_row[20:16],
                                  // cursor_col[27:21], scrolled[28]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // default_attr
);
  import txc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Config register is always writable
  assign cfg_ready = 1'b1;

  txc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  txc_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- sv/txc_checker.sv -----
// Port-level checks for the console writer, bound to the top level.
`include "text_console_writer_top_macros.svh"

module txc_checker #(
  parameter int COLUMNS = txc_pkg::COLUMNS_DEF,
  parameter int ROWS    = txc_pkg::ROWS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A stalled result holds
  `TXC_CHECK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Cursor column stays on screen
  `TXC_CHECK_IMP(a_col_range, out_tvalid, {1'b0, out_tdata[27:21]} < 8'(COLUMNS), "cursor column off screen")

  // Cursor row stays on screen where the field shows it whole
  `TXC_CHECK_IMP(a_row_range, out_tvalid, (ROWS > 32) || ({1'b0, out_tdata[20:16]} < 6'(ROWS)), "cursor row off screen")

  // A scroll leaves the cursor at the start of the bottom row and reads nothing
  `TXC_CHECK_IMP(a_scroll_pos, out_tvalid && out_tdata[28], (out_tdata[20:16] == 5'(ROWS - 1)) && (out_tdata[27:21] == 7'd0) && (out_tdata[15:0] == 16'h0000), "bad cursor after scroll")

  // The blanking pass after reset takes no request
  `TXC_CHECK(a_init_ready, $rose(rst_n) |-> !in_tready, "request taken during reset clear")

endmodule

bind text_console_writer_top txc_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_txc_checker (.*);

// ----- tb/sv/text_console_writer_top_tb.sv -----
// Self-checking testbench for the text console writer: predicts every result.
module text_console_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import txc_pkg::*;

  localparam int N_COLS  = COLUMNS_DEF;
  localparam int N_ROWS  = ROWS_DEF;
  localparam int N_CELLS = N_COLS * N_ROWS;

  // Request kind the block leaves alone
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Worst case: every item a full-screen sweep plus stalls, taken several times
  localparam longint CYCLE_LIMIT = 5_000_000;
  localparam int     PHASE_ITEMS = 200;

  // One result transfer, unpacked
  typedef struct packed {
    logic [15:0] data;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
  } console_result_t;

  // Screen model and queue of expected results
  class console_scoreboard;
    logic [15:0]     cells [N_CELLS];
    int unsigned     row;
    int unsigned     col;
    logic [7:0]      blank_attr;
    console_result_t expected_q [$];
    int unsigned     mismatches;
    int unsigned     checked;
    int unsigned     scrolls;
    int unsigned     clears;
    int unsigned     reads;

    function new();
      blank_attr = ATTR_RST;
      row        = 0;
      col        = 0;
      fill_screen(blank_attr);
    endfunction

    function void fill_screen(logic [7:0] at);
      foreach (cells[i]) cells[i] = {at, CH_SPACE};
    endfunction

    function void set_default_attr(logic [7:0] value);
      blank_attr = value;
    endfunction

    // Step to the next row; past the bottom, shift up and blank the last row
    function bit advance_row(logic [7:0] at);
      row++;
      if (row < N_ROWS) return 1'b0;
      for (int i = 0; i < N_CELLS - N_COLS; i++) cells[i] = cells[i + N_COLS];
      for (int i = N_CELLS - N_COLS; i < N_CELLS; i++) cells[i] = {at, CH_SPACE};
      row = N_ROWS - 1;
      return 1'b1;
    endfunction

    // Called on every accepted request transfer
    function void note_request(logic [1:0] req, logic [7:0] ch, logic [7:0] at,
                               logic [10:0] idx);
      console_result_t want;
      want = '0;
      case (req)
        REQ_PUT: begin
          if (ch == CH_NEWLINE) begin
            col = 0;
            want.scrolled = advance_row(at);
          end else if (ch == CH_RETURN) begin
            col = 0;
          end else if (ch == CH_TAB) begin
            col = (col + 8) & ~32'd7;
            if (col >= N_COLS) begin
              col = 0;
              want.scrolled = advance_row(at);
            end
          end else begin
            cells[row * N_COLS + col] = {at, ch};
            col++;
            if (col >= N_COLS) begin
              col = 0;
              want.scrolled = advance_row(at);
            end
          end
        end
        REQ_CLEAR: begin
          fill_screen(blank_attr);
          row = 0;
          col = 0;
          clears++;
        end
        REQ_READ: begin
          reads++;
          if (idx < N_CELLS) want.data = cells[idx];
        end
        default: ;
      endcase
      want.row = 5'(row);
      want.col = 7'(col);
      if (want.scrolled) scrolls++;
      expected_q.push_back(want);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    // Called on every accepted result transfer
    function void check_result(logic [31:0] word);
      console_result_t got;
      console_result_t want;
      got.data     = word[15:0];
      got.row      = word[20:16];
      got.col      = word[27:21];
      got.scrolled = word[28];
      checked++;
      if (expected_q.size() == 0) begin
        flag($sformatf("result %h with nothing expected", word));
        return;
      end
      want = expected_q.pop_front();
      if (got.data != want.data || got.row != want.row || got.col != want.col ||
          got.scrolled != want.scrolled)
        flag($sformatf("result %0d: expected data %h row %0d col %0d scrolled %0b, got %h %0d %0d %0b",
                       checked, want.data, want.row, want.col, want.scrolled,
                       got.data, got.row, got.col, got.scrolled));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // char_code[7:0], attr[15:8], cell_index[26:16]
  logic [1:0]  in_tuser   = '0;   // req_type[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // read_data[15:0], cursor_row[20:16],
                                  // cursor_col[27:21], scrolled[28]
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;   // default_attr

  console_scoreboard board = new();
  longint      cycle_count = 0;
  int          src_idle = 25;
  int          dst_idle = 65;
  int          sent_count = 0;

  text_console_writer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random back-pressure, check each transfer
  always @(negedge clk) out_tready <= ($urandom_range(99) >= dst_idle);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // One request transfer, with a random gap in front
  task automatic send_request(logic [1:0] req, logic [7:0] ch, logic [7:0] at,
                              logic [10:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {5'd0, idx, at, ch};
    do @(posedge clk); while (!in_tready);
    board.note_request(req, ch, at, idx);
    sent_count++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_default_attr(logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_default_attr(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Read address: anywhere incl. past the screen, the last row, or the cursor row
  function automatic logic [10:0] pick_cell();
    case ($urandom_range(3))
      0:       return 11'($urandom_range(2047));
      1:       return 11'((N_ROWS - 1) * N_COLS + $urandom_range(N_COLS - 1));
      2:       return 11'(board.row * N_COLS + $urandom_range(N_COLS - 1));
      default: return 11'($urandom_range(N_CELLS - 1));
    endcase
  endfunction

  // A line of text with embedded reads and controls, usually ending in newline
  task automatic send_line();
    int          len;
    int          pick;
    logic [7:0]  at;
    at  = 8'($urandom_range(255));
    len = ($urandom_range(9) == 0) ? $urandom_range(60, 100) : $urandom_range(12);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 20)
        send_request(REQ_READ, 8'($urandom), 8'($urandom), pick_cell());
      else if (pick < 28)
        send_request(REQ_PUT, CH_TAB, at, 11'($urandom));
      else if (pick < 31)
        send_request(REQ_PUT, CH_RETURN, at, 11'($urandom));
      else
        send_request(REQ_PUT, 8'($urandom_range(255)), at, 11'($urandom));
    end
    if ($urandom_range(9) != 0) send_request(REQ_PUT, CH_NEWLINE, at, 11'($urandom));
  endtask

  task automatic run_random(int items);
    int target;
    int pick;
    target = sent_count + items;
    while (sent_count < target) begin
      pick = $urandom_range(99);
      if (pick < 3)
        send_request(REQ_CLEAR, 8'($urandom), 8'($urandom), 11'($urandom));
      else if (pick < 6)
        send_request(REQ_UNUSED, 8'($urandom), 8'($urandom), 11'($urandom));
      else
        send_line();
      if ($urandom_range(19) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register write during the power-up blanking pass
    write_default_attr(8'hFF);

    // Directed: reset contents, read bounds, extreme codes, controls, clear
    send_request(REQ_READ, 8'h00, 8'h00, 11'd0);
    send_request(REQ_READ, 8'hFF, 8'hFF, 11'(N_CELLS - 1));
    send_request(REQ_READ, 8'h00, 8'h00, 11'(N_CELLS));
    send_request(REQ_READ, 8'h00, 8'h00, 11'h7FF);
    send_request(REQ_PUT, 8'h00, 8'h00, 11'h7FF);
    send_request(REQ_PUT, 8'hFF, 8'hFF, 11'h000);
    send_request(REQ_PUT, 8'h80, 8'hA5, 11'h555);
    send_request(REQ_PUT, CH_TAB, 8'h1E, 11'h2AA);
    send_request(REQ_PUT, 8'h7F, 8'h5A, 11'h000);
    send_request(REQ_PUT, CH_RETURN, 8'h3C, 11'h000);
    send_request(REQ_PUT, CH_NEWLINE, 8'hC3, 11'h000);
    send_request(REQ_UNUSED, 8'hFF, 8'hFF, 11'h7FF);
    send_request(REQ_READ, 8'h00, 8'h00, 11'd0);
    send_request(REQ_READ, 8'h00, 8'h00, 11'd1);
    send_request(REQ_READ, 8'h00, 8'h00, 11'd2);
    send_request(REQ_READ, 8'h00, 8'h00, 11'd8);
    send_request(REQ_CLEAR, 8'h00, 8'h00, 11'h000);
    send_request(REQ_READ, 8'h00, 8'h00, 11'd0);
    send_request(REQ_READ, 8'h00, 8'h00, 11'(N_CELLS - 1));
    drain_results();

    // Three random phases, each with its own register setting and idling mix
    write_default_attr(8'h00);
    run_random(PHASE_ITEMS);
    src_idle = 65;
    dst_idle = 25;
    write_default_attr(8'($urandom_range(1, 254)));
    run_random(PHASE_ITEMS);
    src_idle = 0;
    dst_idle = 0;
    write_default_attr(8'hFF);
    run_random(PHASE_ITEMS);

    // Room for any stray result after the last one
    repeat (N_CELLS + 100) @(posedge clk);

    $display("Sent %0d requests, checked %0d results (%0d reads, %0d clears, %0d scrolls)",
             sent_count, board.checked, board.reads, board.clears, board.scrolls);
    $display("Mismatches: %0d, results still expected: %0d", board.mismatches,
             board.pending());
    if (board.mismatches == 0 && board.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/txc_pkg.sv
sv/txc_datapath.sv
sv/txc_ctrl.sv
sv/text_console_writer_top.sv
sv/txc_checker.sv
tb/sv/text_console_writer_top_tb.sv
